// ===== hw/rtl/text_console_ansi_renderer_macros.svh =====
// Assertion macros shared by the console checker.
`ifndef TEXT_CONSOLE_ANSI_RENDERER_MACROS_SVH
`define TEXT_CONSOLE_ANSI_RENDERER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tcar_pkg.sv =====
// Types, character codes and the colour table of the text console.
`default_nettype none

package tcar_pkg;

    // Command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_ESC    = 8'h1b;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_BS     = 8'h08;
    localparam logic [7:0] CHAR_LBRACK = 8'h5b;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_FOUR   = 8'h34;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [7:0] CHAR_UPPER_J = 8'h4a;
    localparam logic [7:0] CHAR_LOWER_M = 8'h6d;
    localparam logic [7:0] CHAR_BLANK  = 8'h20;

    // Attribute values
    localparam logic [7:0] ATTR_NORMAL  = 8'h07;
    localparam logic [7:0] ATTR_BRIGHT  = 8'h0f;
    localparam logic [7:0] ATTR_REVERSE = 8'h70;
    localparam logic [7:0] ATTR_HI_MASK = 8'hf0;
    localparam logic [7:0] ATTR_LO_MASK = 8'h0f;

    // Escape phases
    localparam logic [2:0] PH_NONE    = 3'd0;
    localparam logic [2:0] PH_ESC     = 3'd1;
    localparam logic [2:0] PH_BRACKET = 3'd2;
    localparam logic [2:0] PH_DIGIT   = 3'd3;
    localparam logic [2:0] PH_COLOUR  = 3'd4;

    // Escape first-digit codes
    localparam logic [2:0] DIG_NORMAL  = 3'd0;
    localparam logic [2:0] DIG_BRIGHT  = 3'd1;
    localparam logic [2:0] DIG_CLEAR   = 3'd2;
    localparam logic [2:0] DIG_FG      = 3'd3;
    localparam logic [2:0] DIG_BG      = 3'd4;
    localparam logic [2:0] DIG_REVERSE = 3'd7;

    // Actions a put word asks of the store sequencer
    typedef struct packed {
        logic wr_cell;
        logic clear;
        logic scroll;
    } act_t;

    // Map an ANSI colour digit to the display palette
    function automatic logic [3:0] colour_lookup(input logic [2:0] d);
        logic [3:0] v;
        case (d)
            3'd0:    v = 4'd0;
            3'd1:    v = 4'd4;
            3'd2:    v = 4'd2;
            3'd3:    v = 4'd14;
            3'd4:    v = 4'd1;
            3'd5:    v = 4'd5;
            3'd6:    v = 4'd3;
            default: v = 4'd15;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcar_ram.sv =====
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module tcar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcar_decode.sv =====
// Escape parser and cursor arithmetic for one put word.
`default_nettype none

module tcar_decode #(
    parameter int ROWS = 25,
    parameter int COLS = 80,
    localparam int CELLS = ROWS * COLS,
    localparam int POS_RAW = $clog2(CELLS + COLS),
    localparam int POS_W = (POS_RAW > 11) ? POS_RAW : 11,
    localparam int CW = $clog2(COLS)
) (
    input  wire logic [7:0]  char_byte,
    input  wire logic [POS_W-1:0] pos,
    input  wire logic [CW-1:0]    col,
    input  wire logic [2:0]  phase,
    input  wire logic [2:0]  digit,
    input  wire logic [3:0]  pend,
    input  wire logic [7:0]  attr,
    output logic [POS_W-1:0] pos_next,
    output logic [CW-1:0]    col_next,
    output logic [2:0]       phase_next,
    output logic [2:0]       digit_next,
    output logic [3:0]       pend_next,
    output logic [7:0]       attr_next,
    output tcar_pkg::act_t   act
);

    logic             consumed;
    logic [2:0]       tab_step;
    logic [CW:0]      col_sum;
    logic [POS_W-1:0] pos_move;

    // Escape sequence parser
    always_comb
    begin
        consumed   = 1'b0;
        phase_next = phase;
        digit_next = digit;
        pend_next  = pend;
        attr_next  = attr;
        act        = '0;
        case (phase)
            tcar_pkg::PH_ESC:
            begin
                if (char_byte == tcar_pkg::CHAR_LBRACK)
                begin
                    phase_next = tcar_pkg::PH_BRACKET;
                    consumed   = 1'b1;
                end
            end
            tcar_pkg::PH_BRACKET:
            begin
                if (char_byte inside {[tcar_pkg::CHAR_ZERO:tcar_pkg::CHAR_FOUR],
                                      tcar_pkg::CHAR_SEVEN})
                begin
                    digit_next = char_byte[2:0];
                    phase_next = tcar_pkg::PH_DIGIT;
                    consumed   = 1'b1;
                end
            end
            tcar_pkg::PH_DIGIT:
            begin
                if ((char_byte inside {[tcar_pkg::CHAR_ZERO:tcar_pkg::CHAR_SEVEN]})
                    && (digit inside {tcar_pkg::DIG_FG, tcar_pkg::DIG_BG}))
                begin
                    pend_next  = tcar_pkg::colour_lookup(char_byte[2:0]);
                    phase_next = tcar_pkg::PH_COLOUR;
                    consumed   = 1'b1;
                end
                else if (char_byte == tcar_pkg::CHAR_UPPER_J
                         && digit == tcar_pkg::DIG_CLEAR)
                begin
                    act.clear  = 1'b1;
                    phase_next = tcar_pkg::PH_NONE;
                    consumed   = 1'b1;
                end
                else if (char_byte == tcar_pkg::CHAR_LOWER_M)
                begin
                    case (digit)
                        tcar_pkg::DIG_NORMAL:
                        begin
                            attr_next  = tcar_pkg::ATTR_NORMAL;
                            phase_next = tcar_pkg::PH_NONE;
                            consumed   = 1'b1;
                        end
                        tcar_pkg::DIG_BRIGHT:
                        begin
                            attr_next  = tcar_pkg::ATTR_BRIGHT;
                            phase_next = tcar_pkg::PH_NONE;
                            consumed   = 1'b1;
                        end
                        tcar_pkg::DIG_REVERSE:
                        begin
                            attr_next  = tcar_pkg::ATTR_REVERSE;
                            phase_next = tcar_pkg::PH_NONE;
                            consumed   = 1'b1;
                        end
                        default:
                        begin
                            consumed = 1'b0;
                        end
                    endcase
                end
            end
            tcar_pkg::PH_COLOUR:
            begin
                if (char_byte == tcar_pkg::CHAR_LOWER_M && digit == tcar_pkg::DIG_FG)
                begin
                    attr_next  = (attr & tcar_pkg::ATTR_HI_MASK) | {4'h0, pend};
                    phase_next = tcar_pkg::PH_NONE;
                    consumed   = 1'b1;
                end
                else if (char_byte == tcar_pkg::CHAR_LOWER_M
                         && digit == tcar_pkg::DIG_BG)
                begin
                    attr_next  = (attr & tcar_pkg::ATTR_LO_MASK) | {pend, 4'h0};
                    phase_next = tcar_pkg::PH_NONE;
                    consumed   = 1'b1;
                end
            end
            default:
            begin
                consumed = 1'b0;
            end
        endcase

        // Unconsumed bytes: start an escape or act as text and control
        pos_move = pos;
        col_next = col;
        tab_step = 3'd4 - {1'b0, pos[1:0]};
        col_sum  = {1'b0, col} + (CW+1)'(tab_step);
        if (act.clear)
        begin
            pos_move = '0;
            col_next = '0;
        end
        else if (!consumed)
        begin
            if (char_byte == tcar_pkg::CHAR_ESC)
            begin
                phase_next = tcar_pkg::PH_ESC;
            end
            else
            begin
                phase_next = tcar_pkg::PH_NONE;
                if (char_byte == tcar_pkg::CHAR_CR)
                begin
                    pos_move = pos - POS_W'(col);
                    col_next = '0;
                end
                else if (char_byte == tcar_pkg::CHAR_LF)
                begin
                    pos_move = pos + POS_W'(COLS) - POS_W'(col);
                    col_next = '0;
                end
                else if (char_byte == tcar_pkg::CHAR_TAB)
                begin
                    pos_move = pos + POS_W'(tab_step);
                    if (col_sum >= (CW+1)'(COLS))
                    begin
                        col_next = CW'(col_sum - (CW+1)'(COLS));
                    end
                    else
                    begin
                        col_next = col_sum[CW-1:0];
                    end
                end
                else if (char_byte == tcar_pkg::CHAR_BS)
                begin
                    if (pos != '0)
                    begin
                        pos_move = pos - POS_W'(1);
                        col_next = (col == '0) ? CW'(COLS - 1) : col - CW'(1);
                    end
                end
                else
                begin
                    act.wr_cell = (pos < POS_W'(CELLS));
                    pos_move    = pos + POS_W'(1);
                    col_next    = (col == CW'(COLS - 1)) ? '0 : col + CW'(1);
                end
            end
        end

        // Scroll when the cursor leaves the last row
        pos_next = pos_move;
        if (pos_move >= POS_W'(CELLS))
        begin
            act.scroll = 1'b1;
            pos_next   = pos_move - POS_W'(COLS);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_ansi_renderer.sv =====
// Text console: escape parser, cursor, and a sequencer around the screen store.
// A put or read word is accepted in idle and the store is read; the result register then
// loads in the done state once out_stall allows, and in_stall stays high until then.
// Scroll adds a copy pass plus a bottom-row fill, one cell a cycle;
// clear screen adds a fill pass over every cell through the single write port.
// Reset: async, active low; then a clear pass over every cell with in_stall high.
`default_nettype none

module text_console_ansi_renderer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  char_byte,
    input  wire logic [10:0] cell_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       cell_char,
    output logic [7:0]       cell_attr,
    output logic [10:0]      cursor_cell,
    output logic [7:0]       text_attr
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW = $clog2(CELLS);
    localparam int POS_RAW = $clog2(CELLS + COLS);
    localparam int POS_W = (POS_RAW > 11) ? POS_RAW : 11;
    localparam int CW = $clog2(COLS);
    localparam int IW = (AW > 11) ? AW : 11;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_COPY = 3'd2;
    localparam logic [2:0] ST_FILL = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [2:0]       phase_reg, phase_next;
    logic [2:0]       digit_reg, digit_next;
    logic [3:0]       pend_reg, pend_next;
    logic [7:0]       attr_reg, attr_next;
    logic             rd_ok_reg, rd_ok_next;
    logic [15:0]      fill_val_reg, fill_val_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       cell_char_reg, cell_attr_reg, text_attr_reg;
    logic [10:0]      cursor_cell_reg;
    logic             load_out;

    logic [POS_W-1:0] dec_pos;
    logic [CW-1:0]    dec_col;
    logic [2:0]       dec_phase, dec_digit;
    logic [3:0]       dec_pend;
    logic [7:0]       dec_attr;
    tcar_pkg::act_t   dec_act;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [15:0]      mem_wdata, mem_rdata;
    logic             accept;
    logic [IW-1:0]    idx_ext;

    tcar_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_screen (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    tcar_decode #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_decode (
        .char_byte (char_byte),
        .pos       (pos_reg),
        .col       (col_reg),
        .phase     (phase_reg),
        .digit     (digit_reg),
        .pend      (pend_reg),
        .attr      (attr_reg),
        .pos_next  (dec_pos),
        .col_next  (dec_col),
        .phase_next(dec_phase),
        .digit_next(dec_digit),
        .pend_next (dec_pend),
        .attr_next (dec_attr),
        .act       (dec_act)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign idx_ext  = IW'(cell_index);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Sequence words and sweeps over the screen store
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        col_next      = col_reg;
        phase_next    = phase_reg;
        digit_next    = digit_reg;
        pend_next     = pend_reg;
        attr_next     = attr_reg;
        rd_ok_next    = rd_ok_reg;
        fill_val_next = fill_val_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = fill_val_reg;
        mem_re        = 1'b0;
        mem_raddr     = cnt_reg + AW'(COLS);
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                    if (cmd == tcar_pkg::CMD_READ)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_ext[AW-1:0];
                        rd_ok_next = (32'(cell_index) < 32'(CELLS));
                    end
                    else
                    begin
                        rd_ok_next = 1'b0;
                        pos_next   = dec_pos;
                        col_next   = dec_col;
                        phase_next = dec_phase;
                        digit_next = dec_digit;
                        pend_next  = dec_pend;
                        attr_next  = dec_attr;
                        mem_we     = dec_act.wr_cell;
                        mem_waddr  = pos_reg[AW-1:0];
                        mem_wdata  = {attr_reg, char_byte};
                        cnt_next   = '0;
                        if (dec_act.clear)
                        begin
                            fill_val_next = {attr_reg, tcar_pkg::CHAR_BLANK};
                            state_next    = ST_FILL;
                        end
                        else if (dec_act.scroll)
                        begin
                            state_next = ST_COPY;
                        end
                    end
                end
            end
            ST_COPY:
            begin
                // Read one row down, write the previous read one row up
                mem_re    = (cnt_reg < AW'(CELLS - COLS));
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - AW'(1);
                mem_wdata = mem_rdata;
                if (cnt_reg == AW'(CELLS - COLS))
                begin
                    fill_val_next = '0;
                    state_next    = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_FILL:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                cnt_next   = '0;
            end
        endcase
    end

    // Hold the result word until the consumer takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            pos_reg       <= POS_W'(CELLS - COLS);
            col_reg       <= '0;
            phase_reg     <= tcar_pkg::PH_NONE;
            digit_reg     <= '0;
            pend_reg      <= '0;
            attr_reg      <= tcar_pkg::ATTR_NORMAL;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            digit_reg     <= digit_next;
            pend_reg      <= pend_next;
            attr_reg      <= attr_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fill_val_reg <= fill_val_next;
        if (load_out)
        begin
            cell_char_reg   <= rd_ok_reg ? mem_rdata[7:0] : 8'h00;
            cell_attr_reg   <= rd_ok_reg ? mem_rdata[15:8] : 8'h00;
            cursor_cell_reg <= pos_reg[10:0];
            text_attr_reg   <= attr_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_char   = cell_char_reg;
    assign cell_attr   = cell_attr_reg;
    assign cursor_cell = cursor_cell_reg;
    assign text_attr   = text_attr_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tcar_checker.sv =====
// Port-level checks on the text console, bound to the top level.
`default_nettype none

`include "text_console_ansi_renderer_macros.svh"

module tcar_checker #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  cell_char,
    input wire logic [7:0]  cell_attr,
    input wire logic [10:0] cursor_cell,
    input wire logic [7:0]  text_attr
);

    localparam int CELLS = ROWS * COLS;

    // A stalled result word holds its fields
    `TCAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cell_char) && $stable(cell_attr) && $stable(cursor_cell) && $stable(text_attr), "result word changed while stalled")

    // A result word leaves only when taken
    `TCAR_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(!out_stall), "result word dropped without a take")

    // One word at a time: input stalls right after an accept
    `TCAR_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "input taken while a word is in flight")

    // Cursor stays on the screen
    `TCAR_ASSERT_NOW(a_cursor_range, out_valid, (CELLS > 2048) || (32'(cursor_cell) < 32'(CELLS)), "cursor beyond last cell")

endmodule

bind text_console_ansi_renderer tcar_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
) u_tcar_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cursor_cell(cursor_cell),
    .text_attr  (text_attr)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the text console: directed and random words checked against a local console model.
module tb;
    import tcar_pkg::*;

    localparam int ROWS         = 25;
    localparam int COLS         = 80;
    localparam int CELLS        = ROWS * COLS;
    localparam int TAB_STOP     = 4;
    localparam int RANDOM_WORDS = 760;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_TIME   = 20_000_000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        cmd        = CMD_PUT;
    logic [7:0]  char_byte  = 8'h00;
    logic [10:0] cell_index = 11'd0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [10:0] cursor_cell;
    logic [7:0]  text_attr;

    text_console_ansi_renderer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .char_byte  (char_byte),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr),
        .cursor_cell(cursor_cell),
        .text_attr  (text_attr)
    );

    always #1 clk = ~clk;

    // Expected view of the console after one word
    typedef struct packed {
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [10:0] cursor;
        logic [7:0]  text;
    } console_view_t;

    console_view_t expected_views[$];

    // Shadow copy of the console state
    logic [15:0] shadow_cells [CELLS];
    int          shadow_cursor;
    logic [7:0]  shadow_attr;
    logic [3:0]  shadow_pending;
    logic [2:0]  shadow_phase;
    logic [2:0]  shadow_digit;
    logic [3:0]  palette [8] = '{4'd0, 4'd4, 4'd2, 4'd14, 4'd1, 4'd5, 4'd3, 4'd15};

    int fail_count     = 0;
    int words_sent     = 0;
    int burst_left     = 0;
    bit steady_send    = 1'b0;
    bit long_hold_go   = 1'b0;
    bit long_hold_used = 1'b0;
    int hold_left      = 0;
    int stall_mode     = 0;
    int stall_left     = 0;

    task automatic shadow_reset();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = 16'h0000;
        shadow_cursor  = (ROWS - 1) * COLS;
        shadow_attr    = ATTR_NORMAL;
        shadow_pending = 4'd0;
        shadow_phase   = PH_NONE;
        shadow_digit   = 3'd0;
    endtask

    task automatic shadow_scroll();
        for (int i = COLS; i < CELLS; i++)
            shadow_cells[i - COLS] = shadow_cells[i];
        for (int i = 0; i < COLS; i++)
            shadow_cells[CELLS - COLS + i] = 16'h0000;
        shadow_cursor -= COLS;
    endtask

    task automatic shadow_wipe();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = {shadow_attr, CHAR_BLANK};
        shadow_cursor = 0;
    endtask

    // Advance the escape parser; taken is set when the byte belongs to the escape
    task automatic shadow_escape(input logic [7:0] c, output bit taken);
        taken = 1'b0;
        case (shadow_phase)
            PH_ESC:
            begin
                if (c == CHAR_LBRACK)
                begin
                    shadow_phase = PH_BRACKET;
                    taken = 1'b1;
                end
            end
            PH_BRACKET:
            begin
                if ((c >= CHAR_ZERO && c <= CHAR_FOUR) || c == CHAR_SEVEN)
                begin
                    shadow_digit = c[2:0];
                    shadow_phase = PH_DIGIT;
                    taken = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (c >= CHAR_ZERO && c <= CHAR_SEVEN
                    && (shadow_digit == DIG_FG || shadow_digit == DIG_BG))
                begin
                    shadow_pending = palette[c[2:0]];
                    shadow_phase = PH_COLOUR;
                    taken = 1'b1;
                end
                else if (c == CHAR_UPPER_J && shadow_digit == DIG_CLEAR)
                begin
                    shadow_wipe();
                    shadow_phase = PH_NONE;
                    taken = 1'b1;
                end
                else if (c == CHAR_LOWER_M && (shadow_digit == DIG_NORMAL
                         || shadow_digit == DIG_BRIGHT || shadow_digit == DIG_REVERSE))
                begin
                    case (shadow_digit)
                        DIG_NORMAL: shadow_attr = ATTR_NORMAL;
                        DIG_BRIGHT: shadow_attr = ATTR_BRIGHT;
                        default:    shadow_attr = ATTR_REVERSE;
                    endcase
                    shadow_phase = PH_NONE;
                    taken = 1'b1;
                end
            end
            PH_COLOUR:
            begin
                if (c == CHAR_LOWER_M && shadow_digit == DIG_FG)
                begin
                    shadow_attr = (shadow_attr & ATTR_HI_MASK) | {4'h0, shadow_pending};
                    shadow_phase = PH_NONE;
                    taken = 1'b1;
                end
                else if (c == CHAR_LOWER_M && shadow_digit == DIG_BG)
                begin
                    shadow_attr = (shadow_attr & ATTR_LO_MASK) | {shadow_pending, 4'h0};
                    shadow_phase = PH_NONE;
                    taken = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Apply one put byte: escape, control code, or stored character
    task automatic shadow_put(input logic [7:0] c);
        bit taken;
        shadow_escape(c, taken);
        if (taken)
            return;
        if (c == CHAR_ESC)
        begin
            shadow_phase = PH_ESC;
            return;
        end
        if (c == CHAR_CR)
            shadow_cursor -= shadow_cursor % COLS;
        else if (c == CHAR_LF)
            shadow_cursor += COLS - (shadow_cursor % COLS);
        else if (c == CHAR_TAB)
            shadow_cursor += TAB_STOP - (shadow_cursor % TAB_STOP);
        else if (c == CHAR_BS)
        begin
            if (shadow_cursor > 0)
                shadow_cursor -= 1;
        end
        else
        begin
            if (shadow_cursor < CELLS)
                shadow_cells[shadow_cursor] = {shadow_attr, c};
            shadow_cursor += 1;
        end
        shadow_phase = PH_NONE;
        if (shadow_cursor / COLS >= ROWS)
            shadow_scroll();
    endtask

    // Work out the result of one accepted word and queue it
    task automatic predict_word(input logic c, input logic [7:0] b, input logic [10:0] idx);
        console_view_t v;
        v.ch   = 8'h00;
        v.attr = 8'h00;
        if (c == CMD_READ)
        begin
            if (idx < CELLS)
            begin
                v.ch   = shadow_cells[idx][7:0];
                v.attr = shadow_cells[idx][15:8];
            end
        end
        else
            shadow_put(b);
        v.cursor = 11'(shadow_cursor);
        v.text   = shadow_attr;
        expected_views.push_back(v);
    endtask

    // Offer one word, with random gaps between bursts, and hold it until accepted
    task automatic send_word(input logic c, input logic [7:0] b, input logic [10:0] idx);
        int gap;
        if (!steady_send && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        char_byte  <= b;
        cell_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(c, b, idx);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_put(input logic [7:0] b);
        send_word(CMD_PUT, b, 11'($urandom));
    endtask

    task automatic send_read(input logic [10:0] idx);
        send_word(CMD_READ, 8'($urandom), idx);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_put(s[i]);
    endtask

    // Extremes of the byte, control codes, scroll from the last row, reads at the edges
    task automatic test_controls();
        send_put(8'h00);
        send_put(8'hff);
        send_read(11'd1920);
        send_read(11'd1921);
        send_put(CHAR_CR);
        send_put(CHAR_BS);
        send_put(CHAR_LF);
        send_put(CHAR_LF);
        send_read(11'd1840);
        send_read(11'h7ff);
        send_read(11'(CELLS - 1));
        send_put(CHAR_TAB);
    endtask

    task automatic test_attribute_escapes();
        send_put(CHAR_ESC);
        put_text("[1m");
        send_put(CHAR_ESC);
        put_text("[46m");
        send_put(CHAR_ESC);
        put_text("[33m");
        send_put(CHAR_ESC);
        put_text("[0m");
    endtask

    // Unknown bytes drop the escape and print; a second ESC restarts it
    task automatic test_malformed_escapes();
        send_put(CHAR_ESC);
        put_text("q");
        send_put(CHAR_ESC);
        put_text("[3m");
        send_put(CHAR_ESC);
        send_put(CHAR_ESC);
        put_text("[7m");
    endtask

    // Clear homes the cursor; backspace at cell zero stays put
    task automatic test_clear_and_backspace();
        send_put(CHAR_ESC);
        put_text("[2J");
        send_put(CHAR_BS);
        send_read(11'd0);
        send_read(11'(CELLS - 1));
    endtask

    // Hold the output for a long stretch while words keep coming
    task automatic test_backpressure();
        steady_send  = 1'b1;
        long_hold_go = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 3 == 0)
                send_read(11'($urandom_range(0, CELLS - 1)));
            else
                send_put(8'($urandom_range(8'h20, 8'h7e)));
        end
        steady_send = 1'b0;
    endtask

    task automatic send_random_escape();
        send_put(CHAR_ESC);
        case ($urandom_range(0, 15))
            0, 1:    put_text("[0m");
            2, 3:    put_text("[1m");
            4, 5:    put_text("[7m");
            6, 7, 8, 9, 10:
            begin
                put_text("[3");
                send_put(CHAR_ZERO + 8'($urandom_range(0, 7)));
                send_put(CHAR_LOWER_M);
            end
            11, 12, 13, 14:
            begin
                put_text("[4");
                send_put(CHAR_ZERO + 8'($urandom_range(0, 7)));
                send_put(CHAR_LOWER_M);
            end
            default: put_text("[2J");
        endcase
    endtask

    // Cut an escape short and end it with a near miss or noise
    task automatic send_broken_escape();
        int depth;
        depth = $urandom_range(0, 3);
        send_put(CHAR_ESC);
        if (depth >= 1)
            send_put(CHAR_LBRACK);
        if (depth >= 2)
            send_put(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if (depth >= 3)
            send_put(CHAR_ZERO + 8'($urandom_range(0, 9)));
        case ($urandom_range(0, 4))
            0:       send_put(CHAR_LOWER_M);
            1:       send_put(CHAR_UPPER_J);
            2:       send_put(CHAR_ZERO + 8'($urandom_range(0, 9)));
            3:       send_put(CHAR_ESC);
            default: send_put(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_read(11'($urandom_range(CELLS, 2047)));
                else
                    send_read(11'($urandom_range(0, CELLS - 1)));
            end
            else if (pick < 55)
            begin
                repeat ($urandom_range(1, 12))
                    send_put(8'($urandom_range(8'h20, 8'h7e)));
            end
            else if (pick < 65)
                send_put(8'($urandom_range(0, 255)));
            else if (pick < 77)
            begin
                case ($urandom_range(0, 3))
                    0:       send_put(CHAR_CR);
                    1:       send_put(CHAR_LF);
                    2:       send_put(CHAR_TAB);
                    default: send_put(CHAR_BS);
                endcase
            end
            else if (pick < 90)
                send_random_escape();
            else if (pick < 97)
                send_broken_escape();
            else
            begin
                // run tabs up to and past the last cell
                repeat ($urandom_range(15, 24))
                    send_put(CHAR_TAB);
            end
        end
    endtask

    // Check each result word and drive the output stall pattern
    always @(posedge clk)
    begin
        console_view_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_views.size() == 0)
            begin
                $error("unexpected result word, cursor_cell %0d", cursor_cell);
                fail_count++;
            end
            else
            begin
                want = expected_views.pop_front();
                if (cell_char !== want.ch)
                begin
                    $error("cell_char: expected %02h, got %02h", want.ch, cell_char);
                    fail_count++;
                end
                if (cell_attr !== want.attr)
                begin
                    $error("cell_attr: expected %02h, got %02h", want.attr, cell_attr);
                    fail_count++;
                end
                if (cursor_cell !== want.cursor)
                begin
                    $error("cursor_cell: expected %0d, got %0d", want.cursor, cursor_cell);
                    fail_count++;
                end
                if (text_attr !== want.text)
                begin
                    $error("text_attr: expected %02h, got %02h", want.text, text_attr);
                    fail_count++;
                end
            end
        end

        if (long_hold_go && !long_hold_used)
        begin
            hold_left = LONG_HOLD;
            long_hold_used = 1'b1;
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        else
            stall_left--;

        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    initial
    begin
        shadow_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_controls();
        test_attribute_escapes();
        test_malformed_escapes();
        test_clear_and_backspace();
        test_backpressure();
        test_random_traffic();
        in_valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #LIMIT_TIME;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
